// File: rtl/lle_pkg.sv
// ----------------------------------------------------------------------------
// lle_pkg: shared definitions for the linked list engine
// Request and status codes, controller states and the free map command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lle_pkg;

  // Default pool size and payload width.
  localparam int NODES_DEF = 16;
  localparam int DATA_W    = 32;

  // Request codes carried by a transaction on the input channel.
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_REVERSE    = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_PEEK_FRONT = 3'd5,
    REQ_PEEK_BACK  = 3'd6
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WALK,
    S_PEEK,
    S_DONE
  } state_t;

  // Commands from the controller to the free map.
  typedef struct packed {
    logic start;  // restart the free slot scan at the lowest group
    logic take;   // mark the slot found by the scan as used
    logic rel;    // mark the given node as free again
    logic clr;    // mark every node free
  } fm_cmd_t;

endpackage

`default_nettype wire

// File: rtl/lle_ram.sv
// ----------------------------------------------------------------------------
// lle_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/lle_freemap.sv
// ----------------------------------------------------------------------------
// lle_freemap: node pool allocation map
// One flag per node; a scan walks eight nodes per cycle to find the lowest
// free node, and the controller takes, releases or clears nodes.
// ----------------------------------------------------------------------------
`default_nettype none

module lle_freemap #(
  parameter int NODES = lle_pkg::NODES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lle_pkg::fm_cmd_t         cmd,
  input  wire logic [$clog2(NODES)-1:0] rel_idx,
  output logic                          hit,
  output logic      [$clog2(NODES)-1:0] slot
);

  localparam int IW   = $clog2(NODES);
  localparam int GRP  = 8;
  localparam int NG   = (NODES + GRP - 1) / GRP;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PADW = NG * GRP;

  logic [NODES-1:0] free_r, free_nxt;
  logic [GW-1:0]    grp_r, grp_nxt;

  logic [NG-1:0][GRP-1:0] groups;
  logic [GRP-1:0]         grp_bits;
  logic [2:0]             low_bit;
  logic [GW+2:0]          slot_wide;

  // Split the map into groups of eight; missing nodes read as used.
  assign groups   = PADW'(free_r);
  assign grp_bits = groups[grp_r];
  assign hit      = |grp_bits;

  // Lowest free node within the current group.
  always_comb begin
    low_bit = '0;
    for (int b = GRP - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        low_bit = 3'(b);
      end
    end
  end

  assign slot_wide = {grp_r, low_bit};
  assign slot      = slot_wide[IW-1:0];

  // Scan position: restart on request, otherwise step while nothing is found.
  always_comb begin
    grp_nxt = grp_r;
    if (cmd.start) begin
      grp_nxt = '0;
    end else if (!hit) begin
      grp_nxt = (grp_r == GW'(NG - 1)) ? '0 : grp_r + GW'(1);
    end
  end

  // Flag updates.
  always_comb begin
    free_nxt = free_r;
    if (cmd.clr) begin
      free_nxt = '1;
    end else if (cmd.take) begin
      free_nxt[slot] = 1'b0;
    end else if (cmd.rel) begin
      free_nxt[rel_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
      grp_r  <= '0;
    end else begin
      free_r <= free_nxt;
      grp_r  <= grp_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// linked_list_engine_top: bounded singly linked list engine
// Node values and links live in two synchronous RAMs; a controller walks,
// pushes, removes and reverses the list and a free map allocates nodes.
//
//   Channel | Direction | Ports
//   --------+-----------+-------------------------------------------------
//   in      | input     | in_valid, in_ready, in_req_type, in_value
//   out     | output    | out_valid, out_ready, out_status, out_data,
//           |           | out_count
//
// Clear, a push into a full pool and requests on an empty list go from the
// accept straight to the result register; a peek reads the node RAM first;
// a push scans the free map (8 nodes per cycle), then links the node in;
// remove and reverse read the node RAM once per list node they walk.
// Reset (rst_n low, synchronous) empties the list and frees every node.
// A new request is taken while the previous result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_list_engine_top #(
  parameter int NODES = lle_pkg::NODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [2:0]                       in_req_type,
  input  wire logic signed [lle_pkg::DATA_W-1:0] in_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [1:0]                       out_status,
  output logic signed [lle_pkg::DATA_W-1:0]     out_data,
  output logic      [$clog2(NODES+1)-1:0]       out_count
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int DW = lle_pkg::DATA_W;

  // Control and list state.
  lle_pkg::state_t  state_r, state_nxt;
  lle_pkg::req_t    req_r, req_nxt;
  lle_pkg::status_t res_status_r, res_status_nxt;
  logic [DW-1:0]    value_r, value_nxt;
  logic [DW-1:0]    res_data_r, res_data_nxt;
  logic [IW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [IW-1:0]    prev_r, prev_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    step_r, step_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  lle_pkg::status_t out_status_r, out_status_nxt;
  logic [DW-1:0]    out_data_r, out_data_nxt;
  logic [CW-1:0]    out_count_r, out_count_nxt;
  logic             out_load;

  // RAM and free map connections.
  logic             val_we, link_we;
  logic [IW-1:0]    val_waddr, link_waddr, raddr;
  logic [DW-1:0]    val_wdata, val_rdata;
  logic [IW-1:0]    link_wdata, link_rdata;
  lle_pkg::fm_cmd_t fm_cmd;
  logic [IW-1:0]    fm_rel_idx;
  logic             fm_hit;
  logic [IW-1:0]    fm_slot;

  logic             accept;
  logic             last_step;

  lle_ram #(.WIDTH(DW), .DEPTH(NODES)) u_val_ram (
    .clk     (clk),
    .we      (val_we),
    .waddr   (val_waddr),
    .wdata   (val_wdata),
    .raddr   (raddr),
    .rdata_r (val_rdata)
  );

  lle_ram #(.WIDTH(IW), .DEPTH(NODES)) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .waddr   (link_waddr),
    .wdata   (link_wdata),
    .raddr   (raddr),
    .rdata_r (link_rdata)
  );

  lle_freemap #(.NODES(NODES)) u_freemap (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (fm_cmd),
    .rel_idx (fm_rel_idx),
    .hit     (fm_hit),
    .slot    (fm_slot)
  );

  assign in_ready   = (state_r == lle_pkg::S_IDLE);
  assign accept     = in_valid && in_ready;
  assign last_step  = ((step_r + CW'(1)) == count_r);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;

  // Next state, memory accesses and free map commands.
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    value_nxt      = value_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_load       = 1'b0;
    val_we         = 1'b0;
    val_waddr      = fm_slot;
    val_wdata      = value_r;
    link_we        = 1'b0;
    link_waddr     = cur_r;
    link_wdata     = prev_r;
    raddr          = cur_r;
    fm_cmd         = '0;
    fm_rel_idx     = cur_r;

    unique case (state_r)
      lle_pkg::S_IDLE: begin
        // Start the read a peek or walk needs at the same time as the accept.
        raddr = (in_req_type == lle_pkg::REQ_PEEK_BACK) ? tail_r : head_r;
        if (accept) begin
          req_nxt        = lle_pkg::req_t'(in_req_type);
          value_nxt      = in_value;
          cur_nxt        = head_r;
          prev_nxt       = '0;
          step_nxt       = '0;
          res_data_nxt   = '0;
          res_status_nxt = lle_pkg::ST_OK;
          state_nxt      = lle_pkg::S_DONE;
          unique case (lle_pkg::req_t'(in_req_type))
            lle_pkg::REQ_PUSH_FRONT, lle_pkg::REQ_PUSH_BACK: begin
              if (count_r == CW'(NODES)) begin
                res_status_nxt = lle_pkg::ST_FULL;
              end else begin
                fm_cmd.start = 1'b1;
                state_nxt    = lle_pkg::S_SEARCH;
              end
            end
            lle_pkg::REQ_REMOVE, lle_pkg::REQ_REVERSE: begin
              if (count_r == '0) begin
                res_status_nxt = lle_pkg::ST_EMPTY;
              end else if (in_req_type == lle_pkg::REQ_REMOVE || count_r != CW'(1)) begin
                state_nxt = lle_pkg::S_WALK;
              end
            end
            lle_pkg::REQ_CLEAR: begin
              fm_cmd.clr = 1'b1;
              head_nxt   = '0;
              tail_nxt   = '0;
              count_nxt  = '0;
            end
            lle_pkg::REQ_PEEK_FRONT, lle_pkg::REQ_PEEK_BACK: begin
              if (count_r == '0) begin
                res_status_nxt = lle_pkg::ST_EMPTY;
              end else begin
                state_nxt = lle_pkg::S_PEEK;
              end
            end
            default: begin
              // Unused request code: no change, status ok.
            end
          endcase
        end
      end

      lle_pkg::S_SEARCH: begin
        // Claim the lowest free node and link it in.
        if (fm_hit) begin
          fm_cmd.take = 1'b1;
          val_we      = 1'b1;
          count_nxt   = count_r + CW'(1);
          state_nxt   = lle_pkg::S_DONE;
          if (count_r == '0) begin
            head_nxt = fm_slot;
            tail_nxt = fm_slot;
          end else if (req_r == lle_pkg::REQ_PUSH_FRONT) begin
            link_we    = 1'b1;
            link_waddr = fm_slot;
            link_wdata = head_r;
            head_nxt   = fm_slot;
          end else begin
            link_we    = 1'b1;
            link_waddr = tail_r;
            link_wdata = fm_slot;
            tail_nxt   = fm_slot;
          end
        end
      end

      lle_pkg::S_WALK: begin
        // RAM outputs hold the value and link of node cur_r.
        raddr = link_rdata;
        if (req_r == lle_pkg::REQ_REMOVE) begin
          if (val_rdata == value_r) begin
            res_status_nxt = lle_pkg::ST_OK;
            state_nxt      = lle_pkg::S_DONE;
            count_nxt      = count_r - CW'(1);
            fm_cmd.rel     = 1'b1;
            if (count_r == CW'(1)) begin
              fm_cmd.rel = 1'b0;
              fm_cmd.clr = 1'b1;
              head_nxt   = '0;
              tail_nxt   = '0;
            end else if (step_r == '0) begin
              head_nxt = link_rdata;
            end else if (last_step) begin
              tail_nxt = prev_r;
            end else begin
              link_we    = 1'b1;
              link_waddr = prev_r;
              link_wdata = link_rdata;
            end
          end else if (last_step) begin
            res_status_nxt = lle_pkg::ST_NOTFOUND;
            state_nxt      = lle_pkg::S_DONE;
          end else begin
            prev_nxt = cur_r;
            cur_nxt  = link_rdata;
            step_nxt = step_r + CW'(1);
          end
        end else begin
          // Reverse: point this node back at its predecessor.
          link_we    = 1'b1;
          link_waddr = cur_r;
          link_wdata = prev_r;
          if (last_step) begin
            head_nxt  = tail_r;
            tail_nxt  = head_r;
            state_nxt = lle_pkg::S_DONE;
          end else begin
            prev_nxt = cur_r;
            cur_nxt  = link_rdata;
            step_nxt = step_r + CW'(1);
          end
        end
      end

      lle_pkg::S_PEEK: begin
        res_data_nxt = val_rdata;
        state_nxt    = lle_pkg::S_DONE;
      end

      lle_pkg::S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_count_nxt  = count_r;
          state_nxt      = lle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lle_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lle_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
  end

  // The list never holds more nodes than the pool.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NODES))
    else $error("node count exceeds pool size");

  // A walk never runs past the last node.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lle_pkg::S_WALK) |-> (step_r < count_r))
    else $error("list walk past the tail");

  // A node is only claimed when the scan has found a free one.
  a_take_hit: assert property (@(posedge clk) disable iff (!rst_n)
    fm_cmd.take |-> (fm_hit && count_r != CW'(NODES)))
    else $error("node claimed without a free slot");

  // A full status is only reported with a full pool.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_status_r != lle_pkg::ST_FULL || out_count_r == CW'(NODES)))
    else $error("full status with free nodes left");

endmodule

`default_nettype wire

// File: tb/sv/tb_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_linked_list_engine_top: testbench for the linked list engine
// Drives list requests through the valid/ready input channel, predicts each
// status, peeked value and node count with a behavioral copy of the list, and
// checks every result transaction in order. Directed cases cover the empty,
// single-node and full pool corners; random traffic and a long output
// hold-off cover the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linked_list_engine_top;

  localparam int          NODES      = lle_pkg::NODES_DEF;
  localparam logic [2:0]  REQ_UNUSED = 3'd7;
  localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] VAL_ONES   = 32'hffff_ffff;

  typedef struct {
    lle_pkg::status_t   status;
    logic signed [31:0] data;
    logic        [4:0]  count;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_req_type;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [31:0] out_data;
  logic [4:0]         out_count;

  // Predicted list state.
  logic [31:0] pool_value [NODES];
  int          pool_link  [NODES];
  bit          pool_free  [NODES];
  int          head_idx;
  int          tail_idx;
  int          node_total;

  result_t expected_results [$];
  int      mismatch_count;
  int      results_seen;
  bit      in_gaps_on;
  bit      out_stalls_on;
  int      hold_cycles;

  linked_list_engine_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_count   (out_count)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Free every node and empty the predicted list.
  function automatic void pool_clear();
    for (int i = 0; i < NODES; i++) begin
      pool_free[i] = 1'b1;
    end
    head_idx   = 0;
    tail_idx   = 0;
    node_total = 0;
  endfunction

  // Value stored at list position pos, counted from the head.
  function automatic logic [31:0] list_value_at(input int pos);
    int cur;
    cur = head_idx;
    for (int i = 0; i < pos; i++) begin
      cur = pool_link[cur];
    end
    return pool_value[cur];
  endfunction

  // Apply one request to the predicted list and return the expected result.
  function automatic result_t list_apply(input logic [2:0] req, input logic [31:0] v);
    result_t r;
    int      slot;
    int      cur;
    int      prv;
    int      nxt;
    int      old_head;
    int      pos;
    r.status = lle_pkg::ST_OK;
    r.data   = '0;
    case (req)
      lle_pkg::REQ_PUSH_FRONT, lle_pkg::REQ_PUSH_BACK: begin
        // New nodes always take the lowest free index.
        slot = -1;
        for (int i = 0; i < NODES; i++) begin
          if (pool_free[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          r.status = lle_pkg::ST_FULL;
        end else begin
          pool_free[slot]  = 1'b0;
          pool_value[slot] = v;
          if (node_total == 0) begin
            pool_link[slot] = 0;
            head_idx        = slot;
            tail_idx        = slot;
          end else if (req == lle_pkg::REQ_PUSH_BACK) begin
            pool_link[slot]     = 0;
            pool_link[tail_idx] = slot;
            tail_idx            = slot;
          end else begin
            pool_link[slot] = head_idx;
            head_idx        = slot;
          end
          node_total++;
        end
      end
      lle_pkg::REQ_REMOVE: begin
        if (node_total == 0) begin
          r.status = lle_pkg::ST_EMPTY;
        end else begin
          // Find the first node holding the value.
          cur = head_idx;
          prv = 0;
          pos = 0;
          while (pos < node_total && pool_value[cur] != v) begin
            prv = cur;
            cur = pool_link[cur];
            pos++;
          end
          if (pos == node_total) begin
            r.status = lle_pkg::ST_NOTFOUND;
          end else if (node_total == 1) begin
            pool_clear();
          end else begin
            if (pos == 0) head_idx = pool_link[cur];
            else if (pos == node_total - 1) tail_idx = prv;
            else pool_link[prv] = pool_link[cur];
            pool_free[cur] = 1'b1;
            node_total--;
          end
        end
      end
      lle_pkg::REQ_REVERSE: begin
        if (node_total == 0) begin
          r.status = lle_pkg::ST_EMPTY;
        end else if (node_total > 1) begin
          old_head = head_idx;
          cur      = head_idx;
          prv      = 0;
          nxt      = 0;
          for (int i = 0; i < node_total; i++) begin
            if (i + 1 < node_total) nxt = pool_link[cur];
            pool_link[cur] = prv;
            prv            = cur;
            cur            = nxt;
          end
          head_idx = tail_idx;
          tail_idx = old_head;
        end
      end
      lle_pkg::REQ_CLEAR: begin
        pool_clear();
      end
      lle_pkg::REQ_PEEK_FRONT: begin
        if (node_total == 0) r.status = lle_pkg::ST_EMPTY;
        else r.data = pool_value[head_idx];
      end
      lle_pkg::REQ_PEEK_BACK: begin
        if (node_total == 0) r.status = lle_pkg::ST_EMPTY;
        else r.data = pool_value[tail_idx];
      end
      default: begin
      end
    endcase
    r.count = 5'(node_total);
    return r;
  endfunction

  // Send one request transaction and record its expected result on accept.
  task automatic send_request(input logic [2:0] req, input logic [31:0] v);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_req_type = req;
    in_value    = v;
    do @(posedge clk); while (!in_ready);
    expected_results.insert(expected_results.size(), list_apply(req, v));
    @(negedge clk);
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Values that give duplicates, extremes and fully random bit patterns.
  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7));
      1: return $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return VAL_ONES;
        endcase
      end
      default: begin
        if (node_total > 0) return list_value_at($urandom_range(0, node_total - 1));
        return $urandom();
      end
    endcase
  endfunction

  // Empty-list corners, single node, extremes and every request code.
  task automatic test_directed();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_request(lle_pkg::REQ_PEEK_FRONT, 32'd0);
    send_request(lle_pkg::REQ_PEEK_BACK, 32'd0);
    send_request(lle_pkg::REQ_REMOVE, 32'd5);
    send_request(lle_pkg::REQ_REVERSE, 32'd0);
    send_request(lle_pkg::REQ_CLEAR, 32'd0);
    send_request(REQ_UNUSED, 32'd0);
    send_request(lle_pkg::REQ_PUSH_BACK, VAL_MAX);
    send_request(lle_pkg::REQ_REVERSE, 32'd0);
    send_request(lle_pkg::REQ_PUSH_FRONT, VAL_MIN);
    send_request(lle_pkg::REQ_PUSH_BACK, 32'd0);
    send_request(lle_pkg::REQ_PUSH_FRONT, VAL_ONES);
    send_request(lle_pkg::REQ_PEEK_FRONT, 32'd0);
    send_request(lle_pkg::REQ_PEEK_BACK, 32'd0);
    send_request(lle_pkg::REQ_REVERSE, 32'd0);
    send_request(lle_pkg::REQ_PEEK_FRONT, 32'd0);
    send_request(lle_pkg::REQ_PEEK_BACK, 32'd0);
    send_request(lle_pkg::REQ_REMOVE, 32'd12345);
    // Middle, head and tail removals in that order.
    send_request(lle_pkg::REQ_REMOVE, VAL_MAX);
    send_request(lle_pkg::REQ_REMOVE, 32'd0);
    send_request(lle_pkg::REQ_REMOVE, VAL_ONES);
    send_request(REQ_UNUSED, VAL_ONES);
    send_request(lle_pkg::REQ_REMOVE, VAL_MIN);
    send_request(lle_pkg::REQ_CLEAR, 32'd0);
    send_request(lle_pkg::REQ_PEEK_FRONT, 32'd0);
    wait_drained();
  endtask

  // Fill the pool, push into it while full, then work on the full list.
  task automatic test_pool_full();
    logic [31:0] v;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    for (int i = 0; i < NODES + 2; i++) begin
      v = draw_value();
      send_request((i % 2 == 0) ? lle_pkg::REQ_PUSH_FRONT : lle_pkg::REQ_PUSH_BACK, v);
    end
    send_request(lle_pkg::REQ_PEEK_FRONT, 32'd0);
    send_request(lle_pkg::REQ_PEEK_BACK, 32'd0);
    send_request(lle_pkg::REQ_REVERSE, 32'd0);
    send_request(lle_pkg::REQ_PEEK_FRONT, 32'd0);
    v = list_value_at(node_total - 1);
    send_request(lle_pkg::REQ_REMOVE, v);
    send_request(lle_pkg::REQ_PUSH_BACK, $urandom());
    send_request(lle_pkg::REQ_PEEK_BACK, 32'd0);
    send_request(lle_pkg::REQ_PUSH_FRONT, $urandom());
    wait_drained();
  endtask

  // Random requests with push bias that eases off as the pool fills.
  task automatic test_random_traffic(input int n_items, input bit gaps, input bit stalls);
    int          pick;
    int          push_cut;
    logic [31:0] v;
    in_gaps_on    = gaps;
    out_stalls_on = stalls;
    for (int n = 0; n < n_items; n++) begin
      push_cut = (node_total > 10) ? 25 : 45;
      pick     = $urandom_range(0, 99);
      v        = draw_value();
      if (pick < push_cut) begin
        send_request(pick[0] ? lle_pkg::REQ_PUSH_FRONT : lle_pkg::REQ_PUSH_BACK, v);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Mostly remove a value that is present somewhere in the list.
          if (node_total > 0 && $urandom_range(0, 9) < 6)
            v = list_value_at($urandom_range(0, node_total - 1));
          send_request(lle_pkg::REQ_REMOVE, v);
        end
        else if (pick < 60) send_request(lle_pkg::REQ_REVERSE, v);
        else if (pick < 64) send_request(lle_pkg::REQ_CLEAR, v);
        else if (pick < 80) send_request(lle_pkg::REQ_PEEK_FRONT, v);
        else if (pick < 96) send_request(lle_pkg::REQ_PEEK_BACK, v);
        else send_request(REQ_UNUSED, v);
      end
    end
    wait_drained();
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_output_holdoff();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    hold_cycles   = 150;
    test_random_traffic(60, 1'b0, 1'b0);
  endtask

  // Result receiver: random stalls per transaction, or one long hold-off.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int stall;
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = out_stalls_on ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %0d: status %0d data %0d count %0d",
                   results_seen, out_status, out_data, out_count);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status || out_data !== exp_r.data ||
            out_count !== exp_r.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch %0d: exp st %0d data %0d cnt %0d, got st %0d data %0d cnt %0d",
                     results_seen, exp_r.status, exp_r.data, exp_r.count,
                     out_status, out_data, out_count);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Reset, then run the tests in turn.
  initial begin
    in_valid       = 1'b0;
    in_req_type    = '0;
    in_value       = '0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    in_gaps_on     = 1'b1;
    out_stalls_on  = 1'b1;
    hold_cycles    = 0;
    pool_clear();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_pool_full();
    test_random_traffic(175, 1'b1, 1'b1);
    test_random_traffic(175, 1'b0, 1'b0);
    test_output_holdoff();
    test_random_traffic(175, 1'b1, 1'b0);
    test_random_traffic(175, 1'b0, 1'b1);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
